// ===== rtl/core/ilp_pkg.sv =====
// Shared types and codes for the integer literal parser.
package ilp_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned DIGIT_W = 6;

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [1:0]         status_t;
  typedef logic [1:0]         radix_t;

  localparam status_t ST_OK          = 2'd0;
  localparam status_t ST_LEAD_ZERO   = 2'd1;
  localparam status_t ST_DIGIT_RANGE = 2'd2;
  localparam status_t ST_ILLEGAL     = 2'd3;

  localparam radix_t RX_DEC = 2'd0;
  localparam radix_t RX_HEX = 2'd1;
  localparam radix_t RX_OCT = 2'd2;
  localparam radix_t RX_BIN = 2'd3;

  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_0     = 8'h30;
  localparam char_t CH_9     = 8'h39;
  localparam char_t CH_LA    = 8'h61;
  localparam char_t CH_LZ    = 8'h7a;
  localparam char_t CH_UA    = 8'h41;
  localparam char_t CH_UZ    = 8'h5a;
  localparam char_t CH_X     = 8'h78;
  localparam char_t CH_O     = 8'h6f;
  localparam char_t CH_B     = 8'h62;
  localparam char_t CH_MINUS = 8'h2d;

endpackage

// ===== rtl/core/integer_literal_parser_top.sv =====
// Top level of the radix-prefixed integer literal parser.
// Takes one character per cycle with no gaps between literals. A character
// is registered on transfer; one other than NUL is folded into the parse
// state in the next cycle. A NUL loads the result register and clears the
// parse state once no earlier result is waiting. The only loop is the
// magnitude update, one shift-and-add per character. A waiting result
// stalls a NUL character and those behind it; other characters keep flowing.
module integer_literal_parser_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  character_valid,
  output logic                  character_ready,
  input  ilp_pkg::char_t        character,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic signed [31:0]    value,
  output ilp_pkg::status_t      status
);

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_ZERO   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_SKIP   = 2'd3;

  logic               char_valid;
  ilp_pkg::char_t     char_q;
  logic [1:0]         phase, phase_next;
  ilp_pkg::radix_t    radix_sel, radix_sel_next;
  logic               negative, negative_next;
  ilp_pkg::value_t    magnitude, magnitude_next;
  ilp_pkg::status_t   error_code, error_code_next;

  logic               is_nul, advance;
  logic               is_num, is_lower, is_upper;
  ilp_pkg::digit_t    digit, radix_val;
  ilp_pkg::value_t    scaled, mag_value;
  logic               take;

  assign is_nul  = (char_q == ilp_pkg::CH_NUL);
  assign advance = char_valid && (!is_nul || !result_valid || result_ready);
  assign character_ready = !char_valid || advance;

  assign is_num   = (char_q >= ilp_pkg::CH_0)  && (char_q <= ilp_pkg::CH_9);
  assign is_lower = (char_q >= ilp_pkg::CH_LA) && (char_q <= ilp_pkg::CH_LZ);
  assign is_upper = (char_q >= ilp_pkg::CH_UA) && (char_q <= ilp_pkg::CH_UZ);

  always_comb begin
    digit = '0;
    if (is_num) begin
      digit = ilp_pkg::DIGIT_W'(char_q - ilp_pkg::CH_0);
    end else if (is_lower) begin
      digit = ilp_pkg::DIGIT_W'(char_q - ilp_pkg::CH_LA + 8'd10);
    end else if (is_upper) begin
      digit = ilp_pkg::DIGIT_W'(char_q - ilp_pkg::CH_UA + 8'd10);
    end
  end

  always_comb begin
    unique case (radix_sel)
      ilp_pkg::RX_DEC: begin
        radix_val = 6'd10;
        scaled    = (magnitude << 3) + (magnitude << 1);
      end
      ilp_pkg::RX_HEX: begin
        radix_val = 6'd16;
        scaled    = magnitude << 4;
      end
      ilp_pkg::RX_OCT: begin
        radix_val = 6'd8;
        scaled    = magnitude << 3;
      end
      default: begin
        radix_val = 6'd2;
        scaled    = magnitude << 1;
      end
    endcase
  end

  assign mag_value = negative ? (ilp_pkg::value_t'(0) - magnitude) : magnitude;

  always_comb begin
    phase_next      = phase;
    radix_sel_next  = radix_sel;
    negative_next   = negative;
    magnitude_next  = magnitude;
    error_code_next = error_code;
    take            = 1'b0;
    if (is_nul) begin
      phase_next      = PH_START;
      radix_sel_next  = ilp_pkg::RX_DEC;
      negative_next   = 1'b0;
      magnitude_next  = '0;
      error_code_next = ilp_pkg::ST_OK;
    end else begin
      unique case (phase)
        PH_START: begin
          if (char_q == ilp_pkg::CH_0) begin
            phase_next = PH_ZERO;
          end else if (char_q == ilp_pkg::CH_MINUS) begin
            negative_next = 1'b1;
            phase_next    = PH_DIGITS;
          end else begin
            take = 1'b1;
          end
        end
        PH_ZERO: begin
          if (char_q == ilp_pkg::CH_X) begin
            radix_sel_next = ilp_pkg::RX_HEX;
            phase_next     = PH_DIGITS;
          end else if (char_q == ilp_pkg::CH_O) begin
            radix_sel_next = ilp_pkg::RX_OCT;
            phase_next     = PH_DIGITS;
          end else if (char_q == ilp_pkg::CH_B) begin
            radix_sel_next = ilp_pkg::RX_BIN;
            phase_next     = PH_DIGITS;
          end else begin
            error_code_next = ilp_pkg::ST_LEAD_ZERO;
            phase_next      = PH_SKIP;
          end
        end
        PH_DIGITS: begin
          take = 1'b1;
        end
        default: begin
        end
      endcase
      if (take) begin
        if (!(is_num || is_lower || is_upper)) begin
          error_code_next = ilp_pkg::ST_ILLEGAL;
          phase_next      = PH_SKIP;
        end else if (digit >= radix_val) begin
          error_code_next = ilp_pkg::ST_DIGIT_RANGE;
          phase_next      = PH_SKIP;
        end else begin
          magnitude_next = scaled + ilp_pkg::VALUE_W'(digit);
          phase_next     = PH_DIGITS;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid   <= 1'b0;
      result_valid <= 1'b0;
      phase        <= PH_START;
      radix_sel    <= ilp_pkg::RX_DEC;
      negative     <= 1'b0;
      magnitude    <= '0;
      error_code   <= ilp_pkg::ST_OK;
    end else begin
      if (character_ready) begin
        char_valid <= character_valid;
      end
      if (advance && is_nul) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (advance) begin
        phase      <= phase_next;
        radix_sel  <= radix_sel_next;
        negative   <= negative_next;
        magnitude  <= magnitude_next;
        error_code <= error_code_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (character_valid && character_ready) begin
      char_q <= character;
    end
    if (advance && is_nul) begin
      value  <= (error_code == ilp_pkg::ST_OK) ? signed'(mag_value) : '0;
      status <= error_code;
    end
  end

endmodule

// ===== rtl/core/ilp_checker.sv =====
// Port-level assertions for the integer literal parser, bound to the top level.
module ilp_checker (
  input logic               clk,
  input logic               rst,
  input logic               character_valid,
  input logic               character_ready,
  input ilp_pkg::char_t     character,
  input logic               result_valid,
  input logic               result_ready,
  input logic signed [31:0] value,
  input ilp_pkg::status_t   status
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(value) && $stable(status))
    else $error("result changed while stalled");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ilp_pkg::ST_OK |-> value == 0)
    else $error("error result with nonzero value");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result offered right after reset");

  a_free_input: assert property (@(posedge clk) disable iff (rst)
    !result_valid |=> character_ready || $past(character_valid && character_ready))
    else $error("input stalled with no result waiting");

endmodule

bind integer_literal_parser_top ilp_checker u_ilp_checker (
  .clk             (clk),
  .rst             (rst),
  .character_valid (character_valid),
  .character_ready (character_ready),
  .character       (character),
  .result_valid    (result_valid),
  .result_ready    (result_ready),
  .value           (value),
  .status          (status)
);

// ===== bench/tb_integer_literal_parser_top.sv =====
// Testbench for the integer literal parser: random character streams, scoreboarded results.
module tb_integer_literal_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned CHAR_TARGET  = 1800;
  localparam int unsigned HOLD_START   = 400;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CALM_FIRST   = 1000;
  localparam int unsigned CALM_LAST    = 1400;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_ZERO   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_SKIP   = 2'd3
  } parse_phase_t;

  typedef struct packed {
    ilp_pkg::value_t  value;
    ilp_pkg::status_t status;
  } literal_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                character_valid = 1'b0;
  logic                character_ready;
  ilp_pkg::char_t      character = ilp_pkg::CH_NUL;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic signed [31:0]  value;
  ilp_pkg::status_t    status;

  ilp_pkg::char_t      char_queue[$];
  literal_result_t     expected_results[$];
  int unsigned         cycle_count = 0;
  int unsigned         mismatch_count = 0;
  int unsigned         hold_left = 0;
  bit                  hold_done = 1'b0;

  parse_phase_t        lit_phase = PH_START;
  ilp_pkg::radix_t     lit_radix = ilp_pkg::RX_DEC;
  logic                lit_negative = 1'b0;
  ilp_pkg::value_t     lit_magnitude = '0;
  ilp_pkg::status_t    lit_error = ilp_pkg::ST_OK;

  integer_literal_parser_top dut (
    .clk             (clk),
    .rst             (rst),
    .character_valid (character_valid),
    .character_ready (character_ready),
    .character       (character),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .value           (value),
    .status          (status)
  );

  always #10 clk = ~clk;

  function automatic int unsigned radix_base(input ilp_pkg::radix_t r);
    case (r)
      ilp_pkg::RX_HEX: return 16;
      ilp_pkg::RX_OCT: return 8;
      ilp_pkg::RX_BIN: return 2;
      default:         return 10;
    endcase
  endfunction

  function automatic bit idle_now();
    bit calm;
    calm = (cycle_count >= CALM_FIRST) && (cycle_count < CALM_LAST);
    return !calm && ($urandom_range(99) < 8);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  task automatic flag_error(input ilp_pkg::status_t code);
    lit_error = code;
    lit_phase = PH_SKIP;
  endtask

  task automatic accumulate_digit(input ilp_pkg::char_t c);
    int unsigned digit;
    int unsigned base;
    base = radix_base(lit_radix);
    if (c >= ilp_pkg::CH_0 && c <= ilp_pkg::CH_9) begin
      digit = c - ilp_pkg::CH_0;
    end else if (c >= ilp_pkg::CH_LA && c <= ilp_pkg::CH_LZ) begin
      digit = c - ilp_pkg::CH_LA + 10;
    end else if (c >= ilp_pkg::CH_UA && c <= ilp_pkg::CH_UZ) begin
      digit = c - ilp_pkg::CH_UA + 10;
    end else begin
      flag_error(ilp_pkg::ST_ILLEGAL);
      return;
    end
    if (digit >= base) begin
      flag_error(ilp_pkg::ST_DIGIT_RANGE);
      return;
    end
    lit_magnitude = ilp_pkg::value_t'(lit_magnitude * base + digit);
    lit_phase = PH_DIGITS;
  endtask

  task automatic parse_char(input ilp_pkg::char_t c);
    literal_result_t r;
    if (c == ilp_pkg::CH_NUL) begin
      r.status = lit_error;
      r.value  = '0;
      if (lit_error == ilp_pkg::ST_OK) begin
        r.value = lit_negative ? ilp_pkg::value_t'(-lit_magnitude) : lit_magnitude;
      end
      expected_results.push_back(r);
      lit_phase     = PH_START;
      lit_radix     = ilp_pkg::RX_DEC;
      lit_negative  = 1'b0;
      lit_magnitude = '0;
      lit_error     = ilp_pkg::ST_OK;
      return;
    end
    case (lit_phase)
      PH_START: begin
        if (c == ilp_pkg::CH_0) begin
          lit_phase = PH_ZERO;
        end else if (c == ilp_pkg::CH_MINUS) begin
          lit_negative = 1'b1;
          lit_phase    = PH_DIGITS;
        end else begin
          accumulate_digit(c);
        end
      end
      PH_ZERO: begin
        if (c == ilp_pkg::CH_X) begin
          lit_radix = ilp_pkg::RX_HEX;
          lit_phase = PH_DIGITS;
        end else if (c == ilp_pkg::CH_O) begin
          lit_radix = ilp_pkg::RX_OCT;
          lit_phase = PH_DIGITS;
        end else if (c == ilp_pkg::CH_B) begin
          lit_radix = ilp_pkg::RX_BIN;
          lit_phase = PH_DIGITS;
        end else begin
          flag_error(ilp_pkg::ST_LEAD_ZERO);
        end
      end
      PH_DIGITS: begin
        accumulate_digit(c);
      end
      default: begin
      end
    endcase
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      char_queue.push_back(ilp_pkg::char_t'(s[i]));
    end
    char_queue.push_back(ilp_pkg::CH_NUL);
  endtask

  function automatic ilp_pkg::char_t digit_char(input int unsigned d);
    if (d < 10) begin
      return ilp_pkg::char_t'(ilp_pkg::CH_0 + d);
    end
    return ilp_pkg::char_t'(($urandom_range(1) ? ilp_pkg::CH_LA : ilp_pkg::CH_UA) + d - 10);
  endfunction

  task automatic push_random_literal();
    ilp_pkg::radix_t r;
    int unsigned     base;
    int unsigned     ndig;
    int              bad_at;
    ilp_pkg::char_t  lit[$];
    if ($urandom_range(99) < 80) begin
      r = ilp_pkg::radix_t'($urandom_range(3));
      base = radix_base(r);
      if (r == ilp_pkg::RX_DEC && $urandom_range(3) == 0) begin
        lit.push_back(ilp_pkg::CH_MINUS);
      end
      if (r != ilp_pkg::RX_DEC) begin
        lit.push_back(ilp_pkg::CH_0);
        lit.push_back(r == ilp_pkg::RX_HEX ? ilp_pkg::CH_X :
                      (r == ilp_pkg::RX_OCT ? ilp_pkg::CH_O : ilp_pkg::CH_B));
      end
      ndig = ($urandom_range(9) == 0) ? $urandom_range(33, 12) : $urandom_range(11);
      for (int i = 0; i < ndig; i++) begin
        if (i == 0 && r == ilp_pkg::RX_DEC && lit.size() == 0) begin
          lit.push_back(digit_char($urandom_range(9, 1)));
        end else begin
          lit.push_back(digit_char($urandom_range(base - 1)));
        end
      end
      if ($urandom_range(9) == 0) begin
        bad_at = $urandom_range(lit.size());
        lit.insert(bad_at, ilp_pkg::char_t'($urandom_range(255, 1)));
      end
    end else begin
      if ($urandom_range(3) == 0) begin
        lit.push_back(ilp_pkg::CH_0);
      end
      ndig = $urandom_range(6, 1);
      for (int i = 0; i < ndig; i++) begin
        lit.push_back(ilp_pkg::char_t'($urandom_range(255, 1)));
      end
    end
    foreach (lit[i]) begin
      char_queue.push_back(lit[i]);
    end
    char_queue.push_back(ilp_pkg::CH_NUL);
  endtask

  // sender: hold each character until it transfers
  always @(posedge clk) begin
    if (rst) begin
      character_valid <= 1'b0;
    end else if (!character_valid || character_ready) begin
      if (char_queue.size() != 0 && !idle_now()) begin
        character       <= char_queue.pop_front();
        character_valid <= 1'b1;
      end else begin
        character_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_ready <= 1'b0;
    end else if (!hold_done && cycle_count >= HOLD_START) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else begin
      result_ready <= !idle_now();
    end
  end

  always @(posedge clk) begin
    literal_result_t want;
    if (!rst) begin
      if (character_valid && character_ready) begin
        parse_char(character);
      end
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %0d status %0d", value, status));
        end else begin
          want = expected_results.pop_front();
          if (value !== want.value) begin
            report_mismatch($sformatf("value %0d, want %0d", value, $signed(want.value)));
          end
          if (status !== want.status) begin
            report_mismatch($sformatf("status %0d, want %0d", status, want.status));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("integer_literal_parser_top test failed");
      $finish;
    end
  end

  initial begin
    push_text("");
    push_text("0");
    push_text("07");
    push_text("0x");
    push_text("-");
    push_text("-0x1");
    push_text("0b2z");
    push_text("0xfF");
    char_queue.push_back(8'hff);
    char_queue.push_back(ilp_pkg::CH_NUL);
    while (char_queue.size() < CHAR_TARGET) begin
      push_random_literal();
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (char_queue.size() != 0 || character_valid) begin
      @(posedge clk);
    end
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("integer_literal_parser_top test passed");
    end else begin
      $display("integer_literal_parser_top test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ilp_pkg.sv
rtl/core/integer_literal_parser_top.sv
rtl/core/ilp_checker.sv
bench/tb_integer_literal_parser_top.sv
